// File: rtl/core/point_transform_2d_defines.svh
// assertion macros shared by the point transform rtl
`ifndef POINT_TRANSFORM_2D_DEFINES_SVH
`define POINT_TRANSFORM_2D_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PT2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PT2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pt2d_pkg.sv
// shared types and constants of the point transform pipeline
package pt2d_pkg;

  localparam int COORD_BITS = 16;
  localparam int MIRROR_SUM = 200;
  localparam int Q_FRAC     = 14;

  localparam int FIELD_W = 16;
  localparam int SCALE_W = 8;
  localparam int IDX_W   = 4;
  localparam int OP_W    = FIELD_W + 1;
  localparam int BASE_W  = FIELD_W + 2;
  localparam int PROD_W  = 2 * OP_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RES_W   = SUM_W + 1;

  localparam logic signed [RES_W-1:0] CLAMP_HI =
    RES_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] CLAMP_LO = -CLAMP_HI - RES_W'(1);
  localparam logic [FIELD_W-1:0] SAT_HI_F = CLAMP_HI[FIELD_W-1:0];
  localparam logic [FIELD_W-1:0] SAT_LO_F = CLAMP_LO[FIELD_W-1:0];

  typedef enum logic [3:0] {
    MODE_TRANSLATE = 4'd0,
    MODE_SCALE     = 4'd1,
    MODE_ROT_CW    = 4'd2,
    MODE_ROT_CCW   = 4'd3,
    MODE_MIRROR_Y  = 4'd4,
    MODE_MIRROR_X  = 4'd5,
    MODE_MIRROR_XY = 4'd6,
    MODE_SWAP      = 4'd7,
    MODE_SHEAR_X   = 4'd8,
    MODE_SHEAR_Y   = 4'd9
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE     = 4'd0,
    REG_OFFSET_X = 4'd1,
    REG_OFFSET_Y = 4'd2,
    REG_SCALE_X  = 4'd3,
    REG_SCALE_Y  = 4'd4,
    REG_ROT_COS  = 4'd5,
    REG_ROT_SIN  = 4'd6,
    REG_SHEAR    = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic                      first_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [FIELD_W-1:0] rot_cos;
    logic signed [FIELD_W-1:0] rot_sin;
    logic signed [SCALE_W-1:0] shear_factor;
  } cfg_regs_t;

  // one coordinate: base + (m1a*m1b + m2a*m2b), optionally floored by 2^14
  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic signed [OP_W-1:0]   m1a;
    logic signed [OP_W-1:0]   m1b;
    logic signed [OP_W-1:0]   m2a;
    logic signed [OP_W-1:0]   m2b;
  } coord_ops_t;

  typedef struct packed {
    coord_ops_t cx;
    coord_ops_t cy;
    logic       frac;
  } op_stage_t;

  typedef struct packed {
    logic signed [BASE_W-1:0] base;
    logic signed [PROD_W-1:0] p1;
    logic signed [PROD_W-1:0] p2;
  } coord_prod_t;

  typedef struct packed {
    coord_prod_t cx;
    coord_prod_t cy;
    logic        frac;
  } prod_stage_t;

endpackage

// File: rtl/core/pt2d_front.sv
// operand stage: anchor capture and per-mode operand selection
module pt2d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pt2d_pkg::in_item_t   in_data,
  input  pt2d_pkg::cfg_regs_t  cfg,
  input  logic                 s2_load,
  output logic                 s1_valid,
  output pt2d_pkg::op_stage_t  s1_data
);

  logic                                  s1_valid_r, s1_valid_nxt;
  pt2d_pkg::op_stage_t                   s1_data_r, s1_data_nxt;
  logic signed [pt2d_pkg::FIELD_W-1:0]   anchor_x_r, anchor_x_nxt;
  logic signed [pt2d_pkg::FIELD_W-1:0]   anchor_y_r, anchor_y_nxt;
  logic                                  load1, accept;
  logic signed [pt2d_pkg::OP_W-1:0]      x, y, ax, ay, ox, oy, dx, dy;
  logic signed [pt2d_pkg::OP_W-1:0]      c, s, neg_s, sx, sy, sh;
  logic signed [pt2d_pkg::BASE_W-1:0]    xb, yb, mirror_c;

  assign load1    = !s1_valid_r || s2_load;
  assign in_ready = load1;
  assign accept   = in_valid && load1;

  always_comb begin
    x  = pt2d_pkg::OP_W'(in_data.in_x);
    y  = pt2d_pkg::OP_W'(in_data.in_y);
    // a first vertex is its own anchor
    ax = in_data.first_vertex ? x : pt2d_pkg::OP_W'(anchor_x_r);
    ay = in_data.first_vertex ? y : pt2d_pkg::OP_W'(anchor_y_r);
    ox = pt2d_pkg::OP_W'(cfg.offset_x);
    oy = pt2d_pkg::OP_W'(cfg.offset_y);
    dx = x - ox;
    dy = y - oy;
    c  = pt2d_pkg::OP_W'(cfg.rot_cos);
    s  = pt2d_pkg::OP_W'(cfg.rot_sin);
    neg_s = -s;
    sx = pt2d_pkg::OP_W'(cfg.scale_x);
    sy = pt2d_pkg::OP_W'(cfg.scale_y);
    sh = pt2d_pkg::OP_W'(cfg.shear_factor);
    xb = pt2d_pkg::BASE_W'(x);
    yb = pt2d_pkg::BASE_W'(y);
    mirror_c = pt2d_pkg::BASE_W'(pt2d_pkg::MIRROR_SUM);

    s1_data_nxt      = '0;
    s1_data_nxt.cx.base = xb;
    s1_data_nxt.cy.base = yb;
    case (cfg.mode)
      pt2d_pkg::MODE_TRANSLATE: begin
        s1_data_nxt.cx.base = xb + pt2d_pkg::BASE_W'(ox);
        s1_data_nxt.cy.base = yb + pt2d_pkg::BASE_W'(oy);
      end
      pt2d_pkg::MODE_SCALE: begin
        s1_data_nxt.cx.base = pt2d_pkg::BASE_W'(ax);
        s1_data_nxt.cx.m1a  = x - ax;
        s1_data_nxt.cx.m1b  = sx;
        s1_data_nxt.cy.base = pt2d_pkg::BASE_W'(ay);
        s1_data_nxt.cy.m1a  = y - ay;
        s1_data_nxt.cy.m1b  = sy;
      end
      pt2d_pkg::MODE_ROT_CW: begin
        s1_data_nxt.cx = '{base: pt2d_pkg::BASE_W'(ox), m1a: dx, m1b: c, m2a: dy, m2b: neg_s};
        s1_data_nxt.cy = '{base: pt2d_pkg::BASE_W'(oy), m1a: dx, m1b: s, m2a: dy, m2b: c};
        s1_data_nxt.frac = 1'b1;
      end
      pt2d_pkg::MODE_ROT_CCW: begin
        s1_data_nxt.cx = '{base: pt2d_pkg::BASE_W'(ox), m1a: dx, m1b: c, m2a: dy, m2b: s};
        s1_data_nxt.cy = '{base: pt2d_pkg::BASE_W'(oy), m1a: dy, m1b: c, m2a: dx, m2b: neg_s};
        s1_data_nxt.frac = 1'b1;
      end
      pt2d_pkg::MODE_MIRROR_Y: begin
        s1_data_nxt.cy.base = mirror_c - yb;
      end
      pt2d_pkg::MODE_MIRROR_X: begin
        s1_data_nxt.cx.base = mirror_c - xb;
      end
      pt2d_pkg::MODE_MIRROR_XY: begin
        s1_data_nxt.cx.base = mirror_c - xb;
        s1_data_nxt.cy.base = mirror_c - yb;
      end
      pt2d_pkg::MODE_SWAP: begin
        s1_data_nxt.cx.base = yb;
        s1_data_nxt.cy.base = xb;
      end
      pt2d_pkg::MODE_SHEAR_X: begin
        s1_data_nxt.cx.m1a = y;
        s1_data_nxt.cx.m1b = sh;
      end
      pt2d_pkg::MODE_SHEAR_Y: begin
        s1_data_nxt.cy.m1a = x;
        s1_data_nxt.cy.m1b = sh;
      end
      default: begin
        // unused modes pass the vertex through
      end
    endcase
  end

  always_comb begin
    s1_valid_nxt = load1 ? in_valid : s1_valid_r;
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    if (accept && in_data.first_vertex) begin
      anchor_x_nxt = in_data.in_x;
      anchor_y_nxt = in_data.in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      anchor_x_r <= '0;
      anchor_y_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      anchor_x_r <= anchor_x_nxt;
      anchor_y_r <= anchor_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

// File: rtl/core/pt2d_mul.sv
// multiply stage: four 17x17 signed products
module pt2d_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  pt2d_pkg::op_stage_t   s1_data,
  output logic                  s2_load,
  input  logic                  s3_load,
  output logic                  s2_valid,
  output pt2d_pkg::prod_stage_t s2_data
);

  logic                  s2_valid_r, s2_valid_nxt;
  pt2d_pkg::prod_stage_t s2_data_r, s2_data_nxt;
  logic                  load2;

  assign load2   = !s2_valid_r || s3_load;
  assign s2_load = load2;

  always_comb begin
    s2_data_nxt.cx.base = s1_data.cx.base;
    s2_data_nxt.cx.p1   = s1_data.cx.m1a * s1_data.cx.m1b;
    s2_data_nxt.cx.p2   = s1_data.cx.m2a * s1_data.cx.m2b;
    s2_data_nxt.cy.base = s1_data.cy.base;
    s2_data_nxt.cy.p1   = s1_data.cy.m1a * s1_data.cy.m1b;
    s2_data_nxt.cy.p2   = s1_data.cy.m2a * s1_data.cy.m2b;
    s2_data_nxt.frac    = s1_data.frac;
    s2_valid_nxt        = load2 ? s1_valid : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load2 && s1_valid) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;

endmodule

// File: rtl/core/pt2d_back.sv
// sum and floor stage, then final add, clamp and output register
module pt2d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s2_valid,
  input  pt2d_pkg::prod_stage_t s2_data,
  output logic                  s3_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pt2d_pkg::out_item_t   out_data
);

  logic                                s3_valid_r, s3_valid_nxt;
  logic signed [pt2d_pkg::BASE_W-1:0]  bx_r, by_r;
  logic signed [pt2d_pkg::SUM_W-1:0]   tx_r, ty_r, tx_nxt, ty_nxt, sum_x, sum_y;
  logic                                out_valid_r, out_valid_nxt;
  pt2d_pkg::out_item_t                 out_data_r, out_data_nxt;
  logic                                load3, load_o;
  logic signed [pt2d_pkg::RES_W-1:0]   rx, ry, cx, cy;
  logic                                sat_x, sat_y;

  assign load_o  = !out_valid_r || out_ready;
  assign load3   = !s3_valid_r || load_o;
  assign s3_load = load3;

  always_comb begin
    sum_x = pt2d_pkg::SUM_W'(s2_data.cx.p1) + pt2d_pkg::SUM_W'(s2_data.cx.p2);
    sum_y = pt2d_pkg::SUM_W'(s2_data.cy.p1) + pt2d_pkg::SUM_W'(s2_data.cy.p2);
    // arithmetic shift gives the floor for rotation
    tx_nxt = s2_data.frac ? (sum_x >>> pt2d_pkg::Q_FRAC) : sum_x;
    ty_nxt = s2_data.frac ? (sum_y >>> pt2d_pkg::Q_FRAC) : sum_y;
    s3_valid_nxt = load3 ? s2_valid : s3_valid_r;
  end

  always_comb begin
    rx = pt2d_pkg::RES_W'(bx_r) + pt2d_pkg::RES_W'(tx_r);
    ry = pt2d_pkg::RES_W'(by_r) + pt2d_pkg::RES_W'(ty_r);
    sat_x = (rx > pt2d_pkg::CLAMP_HI) || (rx < pt2d_pkg::CLAMP_LO);
    sat_y = (ry > pt2d_pkg::CLAMP_HI) || (ry < pt2d_pkg::CLAMP_LO);
    cx = (rx > pt2d_pkg::CLAMP_HI) ? pt2d_pkg::CLAMP_HI :
         (rx < pt2d_pkg::CLAMP_LO) ? pt2d_pkg::CLAMP_LO : rx;
    cy = (ry > pt2d_pkg::CLAMP_HI) ? pt2d_pkg::CLAMP_HI :
         (ry < pt2d_pkg::CLAMP_LO) ? pt2d_pkg::CLAMP_LO : ry;
    out_data_nxt.out_x     = cx[pt2d_pkg::FIELD_W-1:0];
    out_data_nxt.out_y     = cy[pt2d_pkg::FIELD_W-1:0];
    out_data_nxt.saturated = sat_x || sat_y;
    out_valid_nxt = load_o ? s3_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load3 && s2_valid) begin
      bx_r <= s2_data.cx.base;
      by_r <= s2_data.cy.base;
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
    end
    if (load_o && s3_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/point_transform_2d.sv
// top level of the 2d vertex transform pipeline
// an accepted item passes the operand, multiply, sum and clamp registers in turn on its way to out_valid
// throughput: one item per cycle; each stage moves on when the next one frees up
// the four stages are set by the two-level product sum feeding a wide clamp
// reset (rst_n low, synchronous): pipeline emptied, anchor zeroed, registers to defaults
// configuration writes take effect at once, cfg_ready is always high
`include "point_transform_2d_defines.svh"

module point_transform_2d (
  input  logic                                clk,
  input  logic                                rst_n,
  // vertex input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pt2d_pkg::in_item_t                  in_data,
  // transformed vertex channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output pt2d_pkg::out_item_t                 out_data,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pt2d_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pt2d_pkg::FIELD_W-1:0]        cfg_data
);

  pt2d_pkg::cfg_regs_t   cfg_r, cfg_nxt;
  logic                  s1_valid, s2_valid;
  logic                  s2_load, s3_load;
  pt2d_pkg::op_stage_t   s1_data;
  pt2d_pkg::prod_stage_t s2_data;
  logic                  out_at_bound;

  // register file: always ready, writes past the last index are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (pt2d_pkg::reg_idx_t'(cfg_index))
        pt2d_pkg::REG_MODE:     cfg_nxt.mode = pt2d_pkg::mode_t'(cfg_data[3:0]);
        pt2d_pkg::REG_OFFSET_X: cfg_nxt.offset_x = cfg_data;
        pt2d_pkg::REG_OFFSET_Y: cfg_nxt.offset_y = cfg_data;
        pt2d_pkg::REG_SCALE_X:  cfg_nxt.scale_x = cfg_data[pt2d_pkg::SCALE_W-1:0];
        pt2d_pkg::REG_SCALE_Y:  cfg_nxt.scale_y = cfg_data[pt2d_pkg::SCALE_W-1:0];
        pt2d_pkg::REG_ROT_COS:  cfg_nxt.rot_cos = cfg_data;
        pt2d_pkg::REG_ROT_SIN:  cfg_nxt.rot_sin = cfg_data;
        pt2d_pkg::REG_SHEAR:    cfg_nxt.shear_factor = cfg_data[pt2d_pkg::SCALE_W-1:0];
        default: begin
          // index beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= pt2d_pkg::MODE_TRANSLATE;
      cfg_r.offset_x     <= '0;
      cfg_r.offset_y     <= '0;
      cfg_r.scale_x      <= pt2d_pkg::SCALE_W'(1);
      cfg_r.scale_y      <= pt2d_pkg::SCALE_W'(1);
      cfg_r.rot_cos      <= pt2d_pkg::FIELD_W'(1 << pt2d_pkg::Q_FRAC);
      cfg_r.rot_sin      <= '0;
      cfg_r.shear_factor <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage 1: anchor capture and operand selection by mode
  pt2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .s2_load  (s2_load),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  // stage 2: the four signed products
  pt2d_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s2_load  (s2_load),
    .s3_load  (s3_load),
    .s2_valid (s2_valid),
    .s2_data  (s2_data)
  );

  // stages 3 and 4: product sum with floor, then base add and clamp
  pt2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .s3_load   (s3_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // some coordinate of the result sits on a clamp bound
  assign out_at_bound = (out_data.out_x == pt2d_pkg::SAT_HI_F) ||
                        (out_data.out_x == pt2d_pkg::SAT_LO_F) ||
                        (out_data.out_y == pt2d_pkg::SAT_HI_F) ||
                        (out_data.out_y == pt2d_pkg::SAT_LO_F);

  // the pipeline only pushes back when the output holds an item
  `PT2D_ASSERT_NOW(a_stall_from_output, !in_ready, out_valid, "input stalled with empty output")
  // an accepted item lands in the operand stage
  `PT2D_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_valid, "accepted item lost")
  // a flagged result carries a clamp bound in at least one coordinate
  `PT2D_ASSERT_NOW(a_sat_at_bound, out_valid && out_data.saturated, out_at_bound, "saturated flag without clamped value")

endmodule

// File: tb/point_transform_2d_tb.sv
// self-checking testbench for the 2d vertex transform pipeline
module point_transform_2d_tb;
  import pt2d_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int PIPE_LATENCY   = 4;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int ITEMS_PER_SEG  = 54;
  localparam int NUM_SEGMENTS   = 12;
  localparam int LONG_HOLD      = 80;

  // codes the package leaves unnamed: top mode code and a register slot with no register
  localparam logic [3:0]       MODE_CODE_MAX = 4'd15;
  localparam logic [IDX_W-1:0] IDX_UNUSED    = 4'd12;

  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [FIELD_W-1:0]   cfg_data  = '0;

  point_transform_2d uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the register file and the polygon anchor
  logic [3:0]                cur_mode  = MODE_TRANSLATE;
  logic signed [FIELD_W-1:0] cur_off_x = '0;
  logic signed [FIELD_W-1:0] cur_off_y = '0;
  logic signed [SCALE_W-1:0] cur_scl_x = 8'sd1;
  logic signed [SCALE_W-1:0] cur_scl_y = 8'sd1;
  logic signed [FIELD_W-1:0] cur_cos   = 16'sd16384;
  logic signed [FIELD_W-1:0] cur_sin   = '0;
  logic signed [SCALE_W-1:0] cur_shear = '0;
  logic signed [FIELD_W-1:0] anc_x     = '0;
  logic signed [FIELD_W-1:0] anc_y     = '0;

  in_item_t  pending_vertices[$];   // vertices waiting to be offered
  out_item_t expected_vertices[$];  // transformed vertices still to come out
  out_item_t want;
  int        mismatches     = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_left      = 0;

  // clock and watchdog
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("CHECKS FAILED");
    $finish;
  end

  // saturate to the coordinate range, flag any clamp
  function automatic longint clamp_coord(input longint v, inout logic hit);
    if (v > COORD_MAX) begin
      hit = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      hit = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // expected output for one accepted vertex; also moves the anchor
  function automatic out_item_t transform_vertex(input in_item_t v);
    longint    x, y, rx, ry, dx, dy, ox, oy, c, s, ax, ay;
    logic      hit;
    out_item_t r;
    x = $signed(v.in_x);
    y = $signed(v.in_y);
    // anchor is taken before the transform, whatever the mode
    if (v.first_vertex) begin
      anc_x = v.in_x;
      anc_y = v.in_y;
    end
    ax  = anc_x;
    ay  = anc_y;
    ox  = cur_off_x;
    oy  = cur_off_y;
    c   = cur_cos;
    s   = cur_sin;
    dx  = x - ox;
    dy  = y - oy;
    rx  = x;
    ry  = y;
    hit = 1'b0;
    case (cur_mode)
      MODE_TRANSLATE: begin
        rx = x + ox;
        ry = y + oy;
      end
      MODE_SCALE: begin
        rx = ax + (x - ax) * longint'(cur_scl_x);
        ry = ay + (y - ay) * longint'(cur_scl_y);
      end
      // arithmetic shift of the wide sum is the floor by 2^14
      MODE_ROT_CW: begin
        rx = ox + ((dx * c - dy * s) >>> Q_FRAC);
        ry = oy + ((dx * s + dy * c) >>> Q_FRAC);
      end
      MODE_ROT_CCW: begin
        rx = ox + ((dx * c + dy * s) >>> Q_FRAC);
        ry = oy + ((dy * c - dx * s) >>> Q_FRAC);
      end
      MODE_MIRROR_Y: ry = longint'(MIRROR_SUM) - y;
      MODE_MIRROR_X: rx = longint'(MIRROR_SUM) - x;
      MODE_MIRROR_XY: begin
        rx = longint'(MIRROR_SUM) - x;
        ry = longint'(MIRROR_SUM) - y;
      end
      MODE_SWAP: begin
        rx = y;
        ry = x;
      end
      MODE_SHEAR_X: rx = x + longint'(cur_shear) * y;
      MODE_SHEAR_Y: ry = y + longint'(cur_shear) * x;
      default: ;  // unused codes pass the vertex through
    endcase
    rx = clamp_coord(rx, hit);
    ry = clamp_coord(ry, hit);
    r.out_x     = rx[FIELD_W-1:0];
    r.out_y     = ry[FIELD_W-1:0];
    r.saturated = hit;
    return r;
  endfunction

  // sender: keeps valid and payload steady until the item is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_vertices.push_back(transform_vertex(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_vertices.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every taken item in order, stalls at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          $display("%0t unexpected item: expected none, got x=%0d y=%0d sat=%b", $time,
                   $signed(out_data.out_x), $signed(out_data.out_y), out_data.saturated);
        end else begin
          want = expected_vertices.pop_front();
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t mismatch: expected x=%0d y=%0d sat=%b, got x=%0d y=%0d sat=%b",
                     $time, $signed(want.out_x), $signed(want.out_y), want.saturated,
                     $signed(out_data.out_x), $signed(out_data.out_y), out_data.saturated);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // one register write; called at a rising edge, leaves cfg_valid high
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:     cur_mode  = val[3:0];
      REG_OFFSET_X: cur_off_x = val;
      REG_OFFSET_Y: cur_off_y = val;
      REG_SCALE_X:  cur_scl_x = val[SCALE_W-1:0];
      REG_SCALE_Y:  cur_scl_y = val[SCALE_W-1:0];
      REG_ROT_COS:  cur_cos   = val;
      REG_ROT_SIN:  cur_sin   = val;
      REG_SHEAR:    cur_shear = val[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // pipeline empty: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    @(negedge clk);
    while (pending_vertices.size() != 0 || in_valid || expected_vertices.size() != 0)
      @(negedge clk);
  endtask

  task automatic begin_writes();
    wait_drained();
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_vertex(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                            input logic first);
    in_item_t v;
    v.in_x         = x;
    v.in_y         = y;
    v.first_vertex = first;
    pending_vertices.push_back(v);
  endtask

  // coordinate or offset: extremes, the mirror sum, full range, half the time a small window
  function automatic logic [FIELD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'(MIRROR_SUM);
      3, 4:    return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // 8-bit factor in the low byte, junk above it
  function automatic logic [FIELD_W-1:0] rand_factor();
    logic [SCALE_W-1:0] f;
    case ($urandom_range(0, 7))
      0:       f = 8'h80;
      1:       f = 8'h7F;
      2:       f = 8'($urandom);
      default: f = 8'(int'($urandom_range(0, 8)) - 4);
    endcase
    return {8'($urandom), f};
  endfunction

  function automatic logic [FIELD_W-1:0] rand_trig();
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom);
    return 16'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_setting(input logic [3:0] mode);
    begin_writes();
    write_reg(REG_MODE, 16'(mode));
    write_reg(REG_OFFSET_X, rand_coord());
    write_reg(REG_OFFSET_Y, rand_coord());
    write_reg(REG_SCALE_X, rand_factor());
    write_reg(REG_SCALE_Y, rand_factor());
    write_reg(REG_ROT_COS, rand_trig());
    write_reg(REG_ROT_SIN, rand_trig());
    write_reg(REG_SHEAR, rand_factor());
    end_writes();
  endtask

  // polygons: a flagged first vertex then more; a few stray or missing flags as noise
  task automatic add_polygons(input int n_items);
    int sides;
    while (n_items > 0) begin
      sides = $urandom_range(1, 8);
      for (int k = 0; k < sides && n_items > 0; k++) begin
        if (k == 0)
          add_vertex(rand_coord(), rand_coord(), $urandom_range(0, 7) != 0);
        else
          add_vertex(rand_coord(), rand_coord(), $urandom_range(0, 15) == 0);
        n_items--;
      end
    end
  endtask

  initial begin
    logic [3:0] seg_mode;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: translate by zero, extremes pass straight through
    add_vertex(16'h7FFF, 16'h8000, 1'b0);
    add_vertex(-16'sd1, 16'sd1, 1'b0);

    // scale before any first vertex: anchor still at zero after reset
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_SCALE));
    write_reg(REG_SCALE_X, 16'sd127);
    write_reg(REG_SCALE_Y, -16'sd128);
    end_writes();
    add_vertex(16'sd3, -16'sd2, 1'b0);
    add_vertex(16'sd100, 16'sd50, 1'b1);        // first vertex maps onto itself
    add_vertex(16'h8000, 16'h7FFF, 1'b0);

    // translate at the offset extremes, anchor caught outside scale mode
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_TRANSLATE));
    write_reg(REG_OFFSET_X, 16'h7FFF);
    write_reg(REG_OFFSET_Y, 16'h8000);
    end_writes();
    add_vertex(16'sd1, -16'sd1, 1'b1);
    add_vertex(16'h8000, 16'h7FFF, 1'b0);

    // scale about the anchor left by translate
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_SCALE));
    write_reg(REG_SCALE_X, -16'sd1);
    write_reg(REG_SCALE_Y, 16'sd2);
    end_writes();
    add_vertex(16'sd5, 16'sd5, 1'b0);
    add_vertex(16'h8000, 16'h8000, 1'b0);

    // rotate cw 45 degrees about a pivot, negative sums exercise the floor
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_ROT_CW));
    write_reg(REG_OFFSET_X, 16'sd100);
    write_reg(REG_OFFSET_Y, -16'sd50);
    write_reg(REG_ROT_COS, 16'sd11585);
    write_reg(REG_ROT_SIN, 16'sd11585);
    end_writes();
    add_vertex(16'h8000, 16'h8000, 1'b0);
    add_vertex(16'sd101, -16'sd49, 1'b0);

    // rotate ccw with trig values far beyond one
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_ROT_CCW));
    write_reg(REG_ROT_COS, 16'h8000);
    write_reg(REG_ROT_SIN, 16'h7FFF);
    end_writes();
    add_vertex(16'h7FFF, 16'h7FFF, 1'b0);
    add_vertex(16'sd0, 16'sd0, 1'b1);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_MIRROR_Y));
    end_writes();
    add_vertex(16'h8000, 16'h8000, 1'b0);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_MIRROR_X));
    end_writes();
    add_vertex(16'h7FFF, 16'sd0, 1'b1);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_MIRROR_XY));
    end_writes();
    add_vertex(16'h8000, 16'h7FFF, 1'b0);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_SWAP));
    end_writes();
    add_vertex(16'sd1, 16'h8000, 1'b0);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_SHEAR_X));
    write_reg(REG_SHEAR, -16'sd128);
    end_writes();
    add_vertex(16'h7FFF, 16'h7FFF, 1'b0);
    add_vertex(-16'sd3, 16'sd2, 1'b0);

    begin_writes();
    write_reg(REG_MODE, 16'(MODE_SHEAR_Y));
    write_reg(REG_SHEAR, 16'sd127);
    end_writes();
    add_vertex(-16'sd5, 16'sd3, 1'b0);
    add_vertex(16'h7FFF, 16'sd1, 1'b0);

    // unused mode code passes through; a write to an empty slot changes nothing
    begin_writes();
    write_reg(REG_MODE, 16'(MODE_CODE_MAX));
    write_reg(IDX_UNUSED, 16'hFFFF);
    end_writes();
    add_vertex(16'sd123, -16'sd456, 1'b1);

    // random segments: each mode in turn, then unused codes, then any mode
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      if (seg <= MODE_SHEAR_Y)
        seg_mode = 4'(seg);
      else if (seg == MODE_SHEAR_Y + 1)
        seg_mode = 4'($urandom_range(MODE_SHEAR_Y + 1, MODE_CODE_MAX));
      else
        seg_mode = 4'($urandom_range(MODE_TRANSLATE, MODE_SHEAR_Y));
      random_setting(seg_mode);

      // idling pattern rotates: none, sender, receiver, both
      case (seg % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase

      if (seg == 4) begin
        // long receiver hold while the sender keeps offering: pipe fills, input stalls
        add_polygons(ITEMS_PER_SEG);
        hold_left = LONG_HOLD;
      end else if (seg == 6) begin
        // sender pauses midway until every owed item has come out
        add_polygons(ITEMS_PER_SEG / 2);
        wait_drained();
        add_polygons(ITEMS_PER_SEG - ITEMS_PER_SEG / 2);
      end else begin
        add_polygons(ITEMS_PER_SEG);
      end
      wait_drained();
    end

    // let any stray item show up before the verdict
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
